// ===== design/averaging_voltmeter_display_unit_defines.svh =====
// Assertion macros shared by the voltmeter display RTL.
// Needs a clock named clk and an active-low reset named rst_n in the including module.
`ifndef AVERAGING_VOLTMETER_DISPLAY_UNIT_DEFINES_SVH
`define AVERAGING_VOLTMETER_DISPLAY_UNIT_DEFINES_SVH

// Checked only outside reset.
`define AVD_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define AVD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/avd_pkg.sv =====
// Package for the averaging voltmeter display: sizes, scaling constants,
// BCD split and seven-segment decode. No dependencies.
package avd_pkg;

  localparam int SAMPLES = 8;  // samples per averaging group, 2..16

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = $clog2(SAMPLES * 1023 + 1);
  localparam int CNT_W    = $clog2(SAMPLES);

  // mean = sum / SAMPLES as a reciprocal multiply; exact for sum < 2**SUM_W
  localparam int MEAN_SHIFT = SUM_W + CNT_W;
  localparam int MEAN_MUL   = ((1 << MEAN_SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam int MEAN_MUL_W = MEAN_SHIFT + 1;
  localparam int MEAN_PROD_W = SUM_W + MEAN_MUL_W;

  // tenths = (mean*33 + 511) / 1023; the divide is a reciprocal multiply,
  // exact for dividends below 69977 (largest here is 34270)
  localparam int SCALE_MUL   = 33;
  localparam int SCALE_RND   = 511;
  localparam int SCALE_DIV   = 1023;
  localparam int SCALE_W     = 16;
  localparam int DIV_SHIFT   = 26;
  localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
  localparam int DIV_RECIP_W = 17;
  localparam int DIV_PROD_W  = SCALE_W + DIV_RECIP_W;

  localparam int TENTHS_W = 6;  // 0..33
  localparam int CODE_W   = 6;  // packed BCD on the port
  localparam int SEG_W    = 7;
  localparam int DATA_W   = 16;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] voltage_code;
    logic              decimal_point;
    logic              high_digit;
    logic [SEG_W-1:0]  segments;
  } avd_res_t;

  // 0..33 -> {units, tenths} packed BCD
  function automatic logic [7:0] bcd_of(input logic [TENTHS_W-1:0] v);
    logic [3:0]          units;
    logic [TENTHS_W-1:0] rest;
    begin
      if (v >= TENTHS_W'(30)) begin
        units = 4'd3;
        rest  = v - TENTHS_W'(30);
      end else if (v >= TENTHS_W'(20)) begin
        units = 4'd2;
        rest  = v - TENTHS_W'(20);
      end else if (v >= TENTHS_W'(10)) begin
        units = 4'd1;
        rest  = v - TENTHS_W'(10);
      end else begin
        units = 4'd0;
        rest  = v;
      end
      bcd_of = {units, rest[3:0]};
    end
  endfunction

  // bit0 = a .. bit6 = g; non-decimal digits stay dark
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    begin
      case (d)
        4'd0:    s = 7'h3F;
        4'd1:    s = 7'h06;
        4'd2:    s = 7'h5B;
        4'd3:    s = 7'h4F;
        4'd4:    s = 7'h66;
        4'd5:    s = 7'h6D;
        4'd6:    s = 7'h7D;
        4'd7:    s = 7'h07;
        4'd8:    s = 7'h7F;
        4'd9:    s = 7'h67;
        default: s = 7'h00;
      endcase
      seg_of = s;
    end
  endfunction

endpackage

// ===== design/averaging_voltmeter_display_unit.sv =====
// Averaging voltmeter with two-digit multiplexed seven-segment output.
// Depends on avd_pkg and averaging_voltmeter_display_unit_defines.svh.
//
// Usage:
//   Input stream (in_*): in_tuser is the item kind (0 = converter sample,
//   1 = refresh tick); in_tdata[9:0] is the 10-bit sample. Samples are
//   summed in groups of SAMPLES; the last sample of a group latches the
//   group mean, and the voltage in tenths is derived from it on each tick.
//   Output stream (out_*): one item per tick, none per sample. Ticks show
//   the units digit with decimal point first, then the tenths digit, and
//   so on alternately.
//   A tick's item is registered onto out_* on acceptance when the output register is free.
//   Throughput: one item per cycle, samples and ticks alike, while the skid
//   entry is empty; the cycle holds one add plus a constant multiply (mean
//   on samples, 1/1023 scaling and segment decode on ticks).
//   Stall: the output register is backed by one skid entry, so in_tready
//   is a register and does not follow out_tready combinationally. With
//   the receiver stalled, one further tick lands in the skid entry and
//   in_tready then drops until the skid entry drains.
//   Reset (rst_n low, synchronous): sum and count clear, the shown
//   voltage reads 0.0, the next tick shows the high digit, and both
//   output entries empty.
`include "averaging_voltmeter_display_unit_defines.svh"

module averaging_voltmeter_display_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [avd_pkg::DATA_W-1:0]    in_tdata,   // [9:0] sample, rest zero
  input  logic                          in_tuser,   // [0] opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [avd_pkg::DATA_W-1:0]    out_tdata   // [6:0] segments, [7] high_digit,
                                                    // [8] decimal_point,
                                                    // [14:9] voltage_code, [15] zero
);
  import avd_pkg::*;

  // accumulation state
  logic [SUM_W-1:0]    sum_acc_r, sum_acc_nxt;
  logic [CNT_W-1:0]    sample_count_r, sample_count_nxt;
  logic [SAMPLE_W-1:0] mean_r, mean_nxt;   // mean of last full group
  logic                phase_low_r;

  // output register and skid entry
  logic     out_valid_r, skid_valid_r;
  avd_res_t out_r, skid_r;

  logic                   in_acc, sample_acc, tick_acc, out_free, group_done;
  logic [SUM_W-1:0]       sum_add;
  logic [MEAN_PROD_W-1:0] mean_prod;
  logic [SCALE_W-1:0]     scaled;
  logic [DIV_PROD_W-1:0]  div_prod;
  logic [TENTHS_W-1:0]    tenths;
  logic [7:0]             bcd;
  logic [3:0]             digit;
  avd_res_t               res;

  assign in_tready  = !skid_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign sample_acc = in_acc && (in_tuser == OP_SAMPLE);
  assign tick_acc   = in_acc && (in_tuser == OP_TICK);
  assign out_free   = !out_valid_r || out_tready;

  // sample path: add, then mean by reciprocal multiply at group end
  assign sum_add    = sum_acc_r + SUM_W'(in_tdata[SAMPLE_W-1:0]);
  assign group_done = (sample_count_r == CNT_W'(SAMPLES - 1));
  assign mean_prod  = MEAN_PROD_W'(sum_add) * MEAN_PROD_W'(MEAN_MUL);

  always_comb begin
    sum_acc_nxt      = sum_acc_r;
    sample_count_nxt = sample_count_r;
    mean_nxt         = mean_r;
    if (sample_acc) begin
      if (group_done) begin
        sum_acc_nxt      = '0;
        sample_count_nxt = '0;
        mean_nxt         = mean_prod[MEAN_SHIFT +: SAMPLE_W];
      end else begin
        sum_acc_nxt      = sum_add;
        sample_count_nxt = sample_count_r + CNT_W'(1);
      end
    end
  end

  // tick path: mean*33+511, divide by 1023, split to BCD, decode one digit
  assign scaled   = (SCALE_W'(mean_r) << 5) + SCALE_W'(mean_r) + SCALE_W'(SCALE_RND);
  assign div_prod = DIV_PROD_W'(scaled) * DIV_PROD_W'(DIV_RECIP);
  assign tenths   = div_prod[DIV_SHIFT +: TENTHS_W];
  assign bcd      = bcd_of(tenths);
  assign digit    = phase_low_r ? bcd[3:0] : bcd[7:4];

  always_comb begin
    res.segments      = seg_of(digit);
    res.high_digit    = !phase_low_r;
    res.decimal_point = !phase_low_r;
    res.voltage_code  = bcd[CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_acc_r      <= '0;
      sample_count_r <= '0;
      mean_r         <= '0;
      phase_low_r    <= 1'b0;
    end else begin
      sum_acc_r      <= sum_acc_nxt;
      sample_count_r <= sample_count_nxt;
      mean_r         <= mean_nxt;
      if (tick_acc) begin
        phase_low_r <= !phase_low_r;
      end
    end
  end

  // output side: skid entry drains first; no input is taken while it is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (tick_acc) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (tick_acc) begin
      if (out_free) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};

  `AVD_ASSERT_CLK(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid entry full with output empty")
  `AVD_ASSERT_CLK(a_stall_to_skid, (tick_acc && out_valid_r && !out_tready) |=> skid_valid_r, "stalled tick item lost")
  `AVD_ASSERT_CLK(a_phase_toggle, tick_acc |=> (phase_low_r != $past(phase_low_r)), "digit phase did not alternate")
  `AVD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_r && !skid_valid_r), "output entries not empty after reset")

endmodule

// ===== sim/averaging_voltmeter_display_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for averaging_voltmeter_display_unit: directed table, then random
// sample groups and refresh ticks. Random ticks are checked against a local voltmeter model.
// Depends on avd_pkg and the unit RTL.

module averaging_voltmeter_display_unit_test;
  import avd_pkg::*;

  localparam int RAND_ITEMS = 1000;
  localparam int CALM_ITEMS = 150;   // tail of the run with no idling on either side
  localparam int HOLD_AT    = 300;   // random item that starts the long receiver hold-off
  localparam int HOLD_LEN   = 60;    // cycles the receiver holds off
  localparam int DRAIN_AT   = 600;   // random item before which the sender waits for drain
  localparam int FULL_SCALE = 33;    // 3.3 V in tenths
  localparam int ROUND_ADD  = 511;
  localparam int ADC_MAX    = 1023;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [DATA_W-1:0]   out_tdata;

  averaging_voltmeter_display_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Model state: running group sum/count, BCD code on display, digit phase.
  logic [SUM_W-1:0] group_sum = '0;
  int               group_cnt = 0;
  logic [7:0]       shown_bcd = '0;
  bit               show_low  = 1'b0;

  logic [SEG_W-1:0] digit_segs [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                        7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67};

  avd_res_t expected_digits [$];
  int       fail_count = 0;

  // Handshake flags between sender and receiver processes.
  bit hold_req = 1'b0;
  bit calm     = 1'b0;

  typedef struct {
    logic             op;
    logic [SAMPLE_W-1:0] smp;
    bit               typed;
    avd_res_t         res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Voltmeter model: one accepted item in, zero or one displayed digit out.
  function automatic void volt_step(input logic op, input logic [SAMPLE_W-1:0] smp,
                                    output bit has_res, output avd_res_t res);
    int         mean;
    int         tenths;
    logic [3:0] dig;
    has_res = 1'b0;
    res     = '0;
    if (op == OP_SAMPLE) begin
      group_sum = group_sum + SUM_W'(smp);
      group_cnt++;
      if (group_cnt >= SAMPLES) begin
        // truncated mean, then rounded scaling to tenths of a volt
        mean      = int'(group_sum) / SAMPLES;
        tenths    = (mean * FULL_SCALE + ROUND_ADD) / ADC_MAX;
        shown_bcd = {4'(tenths / 10), 4'(tenths % 10)};
        group_sum = '0;
        group_cnt = 0;
      end
    end else begin
      dig                 = show_low ? shown_bcd[3:0] : shown_bcd[7:4];
      res.segments        = (dig > 4'd9) ? '0 : digit_segs[dig];
      res.high_digit      = !show_low;
      res.decimal_point   = !show_low;
      res.voltage_code    = shown_bcd[CODE_W-1:0];
      show_low            = !show_low;
      has_res             = 1'b1;
    end
  endfunction

  function automatic void report(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0h got %0h", what, want, got);
  endfunction

  task automatic add_row(input logic op, input logic [SAMPLE_W-1:0] smp, input bit typed,
                         input logic [SEG_W-1:0] seg, input logic hi,
                         input logic [CODE_W-1:0] code);
    dir_row_t r;
    r.op                = op;
    r.smp               = smp;
    r.typed             = typed;
    r.res.segments      = seg;
    r.res.high_digit    = hi;
    r.res.decimal_point = hi;
    r.res.voltage_code  = code;
    dir_rows.push_back(r);
  endtask

  // Offer one item; optional idle burst first. Returns at the accepting edge.
  // A typed expectation replaces the model's answer for that item.
  task automatic send(input logic op, input logic [SAMPLE_W-1:0] smp, input bit typed,
                      input avd_res_t typed_res);
    bit       has_res;
    avd_res_t res;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= DATA_W'(smp);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    volt_step(op, smp, has_res, res);
    if (has_res)
      expected_digits.push_back(typed ? typed_res : res);
  endtask

  // Receiver: short random stalls, one long hold-off on request, none in the tail.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker: every accepted output item against the oldest expectation.
  always @(posedge clk) begin : check_out
    avd_res_t got;
    avd_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = avd_res_t'(out_tdata[$bits(avd_res_t)-1:0]);
      if (expected_digits.size() == 0) begin
        report("unexpected item", 0, int'(got));
      end else begin
        want = expected_digits.pop_front();
        if (got.segments !== want.segments)
          report("segments", want.segments, got.segments);
        if (got.high_digit !== want.high_digit)
          report("high_digit", want.high_digit, got.high_digit);
        if (got.decimal_point !== want.decimal_point)
          report("decimal_point", want.decimal_point, got.decimal_point);
        if (got.voltage_code !== want.voltage_code)
          report("voltage_code", want.voltage_code, got.voltage_code);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [SAMPLE_W-1:0] smp;
    logic                op;
    logic [SAMPLE_W-1:0] level;
    int                  mode;
    int                  tick_burst;
    int                  waited;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_SAMPLE;
    in_tdata  <= '0;

    // Directed table. Ticks carry typed results; the sample field on a tick is ignored,
    // so some ticks carry all ones there.
    add_row(OP_TICK, 10'h3FF, 1, 7'h3F, 1'b1, 6'h00);  // after reset: 0.0, high digit first
    add_row(OP_TICK, 10'h000, 1, 7'h3F, 1'b0, 6'h00);
    repeat (SAMPLES) add_row(OP_SAMPLE, 10'h3FF, 0, '0, 1'b0, '0);  // full scale group
    add_row(OP_TICK, 10'h000, 1, 7'h4F, 1'b1, 6'h33);  // 3.3
    add_row(OP_TICK, 10'h000, 1, 7'h4F, 1'b0, 6'h33);
    repeat (SAMPLES / 2) add_row(OP_SAMPLE, 10'h000, 0, '0, 1'b0, '0);
    add_row(OP_TICK, 10'h3FF, 1, 7'h4F, 1'b1, 6'h33);  // mid-group: display unchanged
    repeat (SAMPLES - SAMPLES / 2) add_row(OP_SAMPLE, 10'h000, 0, '0, 1'b0, '0);
    add_row(OP_TICK, 10'h000, 1, 7'h3F, 1'b0, 6'h00);  // zero group completes
    add_row(OP_TICK, 10'h2AA, 1, 7'h3F, 1'b1, 6'h00);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].res);

    // Random part: sample groups whose content follows a per-group pattern,
    // interleaved with ticks.
    mode       = 0;
    level      = '0;
    tick_burst = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= RAND_ITEMS - CALM_ITEMS);
      if (n == HOLD_AT) begin
        // receiver holds off while a run of ticks backs up into the block
        hold_req   = 1'b1;
        tick_burst = 24;
      end
      if (n == DRAIN_AT) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (expected_digits.size() != 0);
      end

      if (tick_burst > 0 || $urandom_range(0, 9) < 3) begin
        op  = OP_TICK;
        smp = SAMPLE_W'($urandom_range(0, ADC_MAX));
        if (tick_burst > 0)
          tick_burst--;
      end else begin
        op = OP_SAMPLE;
        if (group_cnt == 0) begin
          mode  = $urandom_range(0, 3);
          level = SAMPLE_W'($urandom_range(0, ADC_MAX));
        end
        case (mode)
          0:       smp = SAMPLE_W'($urandom_range(0, ADC_MAX));
          1:       smp = level;                                   // exact mean
          2:       smp = $urandom_range(0, 1) ? SAMPLE_W'(ADC_MAX) : '0;
          default: smp = level ^ SAMPLE_W'($urandom_range(0, 3)); // jitter near a level
        endcase
      end
      send(op, smp, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // Drain: bounded wait.
    waited = 0;
    while (expected_digits.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_digits.size() != 0) begin
      fail_count += expected_digits.size();
      $display("%0d expected items never arrived", expected_digits.size());
    end

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
